// File: rtl/core/tppc_pkg.sv
// tppc_pkg: shared widths, command codes, constants and control types of the
// tempo play position control block; used by every module of the block

package tppc_pkg;

   // field and register widths
   localparam int PERIOD_W     = 24;
   localparam int MUL_W        = 24;
   localparam int DIV_W        = 27;
   localparam int CMD_W        = 5;
   localparam int PLAY_COUNT_W = 47;
   localparam int INDEX_W      = 32;
   localparam int OUTPOS_W     = 47;
   localparam int WIDE_W       = 64;

   // parameter defaults
   localparam int POS_W_DEF      = 48;
   localparam int FADE_STEPS_DEF = 10;

   // period limits and reset values
   localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 24'hFFFFFF;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd65536;
   localparam logic [INDEX_W-1:0]  INDEX_MAX    = 32'hFFFFFFFF;
   localparam logic [OUTPOS_W-1:0] OUTPOS_MAX   = {OUTPOS_W{1'b1}};

   // semitone factors in q16
   localparam logic [MUL_W-1:0] Q16_ONE   = 24'd65536;
   localparam logic [MUL_W-1:0] SEMI_Q16  = 24'd69432;
   localparam logic [MUL_W-1:0] SEMI3_Q16 = 24'd77935;

   // register indexes
   localparam logic CSR_NORMAL = 1'b0;
   localparam logic CSR_TARGET = 1'b1;

   // action codes
   localparam logic ACT_TICK = 1'b0;

   // command codes
   localparam logic [CMD_W-1:0] CMD_BACK_FINE     = 5'd0;
   localparam logic [CMD_W-1:0] CMD_FWD_FINE      = 5'd1;
   localparam logic [CMD_W-1:0] CMD_FWD_EIGHTH    = 5'd2;
   localparam logic [CMD_W-1:0] CMD_BACK_1        = 5'd3;
   localparam logic [CMD_W-1:0] CMD_FWD_1         = 5'd4;
   localparam logic [CMD_W-1:0] CMD_BACK_4        = 5'd5;
   localparam logic [CMD_W-1:0] CMD_FWD_4         = 5'd6;
   localparam logic [CMD_W-1:0] CMD_BACK_8        = 5'd7;
   localparam logic [CMD_W-1:0] CMD_FWD_8         = 5'd8;
   localparam logic [CMD_W-1:0] CMD_MARK_MASTER   = 5'd9;
   localparam logic [CMD_W-1:0] CMD_SYNC          = 5'd10;
   localparam logic [CMD_W-1:0] CMD_MARK_TARGET   = 5'd11;
   localparam logic [CMD_W-1:0] CMD_RESTART_BEAT  = 5'd12;
   localparam logic [CMD_W-1:0] CMD_FADE_NORMAL   = 5'd13;
   localparam logic [CMD_W-1:0] CMD_FADE_TARGET   = 5'd14;
   localparam logic [CMD_W-1:0] CMD_TEMPO_NORMAL  = 5'd15;
   localparam logic [CMD_W-1:0] CMD_TEMPO_TARGET  = 5'd16;
   localparam logic [CMD_W-1:0] CMD_SEMI_UP       = 5'd17;
   localparam logic [CMD_W-1:0] CMD_SEMI_DOWN     = 5'd18;
   localparam logic [CMD_W-1:0] CMD_SEMI3_DOWN    = 5'd19;
   localparam logic [CMD_W-1:0] CMD_REWIND        = 5'd20;
   localparam logic [CMD_W-1:0] CMD_RESET_PLAY    = 5'd21;

   // operand selection of the multiply-divide unit
   typedef enum logic [3:0] {
      MD_TICK,
      MD_TEMPO,
      MD_FASTER,
      MD_SLOWER,
      MD_SLOWER3,
      MD_FADE,
      MD_SYNC_REM,
      MD_SYNC_Q4,
      MD_PHASE_POS,
      MD_PHASE_MARK
   } md_src_type;

   // state update applied by the datapath
   typedef enum logic [3:0] {
      UPD_NONE,
      UPD_TICK,
      UPD_SIMPLE,
      UPD_FADE_STEP,
      UPD_NEWP,
      UPD_TEMPO,
      UPD_SYNC_REM,
      UPD_SYNC_POS,
      UPD_PHASE_POS,
      UPD_PHASE_MARK
   } upd_type;

   typedef struct packed {
      logic       md_start;
      md_src_type md_src;
      upd_type    upd;
   } ctrl_cmd_type;

   typedef struct packed {
      logic md_done;
      logic rsp_free;
      logic q4_zero;
   } dp_status_type;

endpackage

// File: rtl/core/tempo_play_position_control.sv
// tempo_play_position_control: top level of the variable-speed playback
// address generator; depends on tppc_pkg, tppc_ctrl and tppc_datapath

// Takes one item at a time. A tick costs one pass of the shared multiply-divide
// unit: a multiply over the bits of the normal period up to its highest set bit,
// then a divide, plus control states. Plain nudge, jump, mark and rewind
// commands take no pass; sync takes one or two passes (one when the quarter
// period is zero), restart-at-beat takes two passes; tempo commands take one
// or two passes. A finished tick result waits in an output register while the
// next item is taken; a tick that finishes while that register is still full
// waits for it. The user must write configuration only while the block is
// idle; the block itself does not enforce it.

module tempo_play_position_control
   import tppc_pkg::*;
#(
   parameter int FADE_STEPS     = FADE_STEPS_DEF,
   parameter int POSITION_WIDTH = POS_W_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_action,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [PLAY_COUNT_W-1:0] req_play_count,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [INDEX_W-1:0]      rsp_source_index,
   output logic [OUTPOS_W-1:0]     rsp_out_position,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [PERIOD_W-1:0]     csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          load;

   // input transfer
   assign load = req_valid & req_ready;

   tppc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_action  (req_action),
      .req_command (req_command),
      .status      (status),
      .req_ready   (req_ready),
      .cmd         (cmd)
   );

   tppc_datapath #(
      .PW         (POSITION_WIDTH),
      .FADE_STEPS (FADE_STEPS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .req_command      (req_command),
      .req_play_count   (req_play_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_source_index (rsp_source_index),
      .rsp_out_position (rsp_out_position)
   );

`ifndef SYNTHESIS
   // no new item while a multiply-divide pass finishes
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      status.md_done |-> !req_ready)
      else $error("multiply-divide finished while idle");

   // an accepted item blocks the input channel
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      load |=> !req_ready)
      else $error("input taken again right after a transfer");

   // a result appears only from a tick update
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.upd == UPD_TICK))
      else $error("result without a tick");
`endif

endmodule

// File: rtl/core/tppc_muldiv.sv
// tppc_muldiv: shift-add multiplier followed by a restoring divider,
// floor(a * b / d) saturated to the largest signed position, plus remainder
// depends on tppc_pkg

module tppc_muldiv
   import tppc_pkg::*;
#(
   parameter int PW = POS_W_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [PW-1:0]    a,
   input  logic [MUL_W-1:0] b,
   input  logic [DIV_W-1:0] d,
   output logic             done,
   output logic [PW-1:0]    quot,
   output logic [DIV_W-1:0] rem
);

   localparam int PROD_W = PW + MUL_W;
   localparam int CNT_W  = $clog2(PROD_W + 1);
   localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};

   logic              busy_ff;
   logic              mul_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [PROD_W-1:0] mcand_ff;
   logic [MUL_W-1:0]  mplier_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  dvs_ff;

   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    trial_sub;
   logic              trial_ge;

   // one restoring divide step
   assign trial     = {rem_ff, acc_ff[PROD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign trial_ge  = (trial >= {1'b0, dvs_ff});

   // multiply over the bits of b up to its highest set bit, then one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff   <= 1'b1;
            mul_ff    <= 1'b1;
            acc_ff    <= '0;
            mcand_ff  <= PROD_W'(a);
            mplier_ff <= b;
            rem_ff    <= '0;
            dvs_ff    <= d;
         end else if (busy_ff) begin
            if (mul_ff) begin
               if (mplier_ff == '0) begin
                  mul_ff <= 1'b0;
                  cnt_ff <= CNT_W'(PROD_W);
               end else begin
                  acc_ff    <= acc_ff + (mplier_ff[0] ? mcand_ff : '0);
                  mcand_ff  <= mcand_ff << 1;
                  mplier_ff <= mplier_ff >> 1;
               end
            end else begin
               rem_ff <= trial_ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
               acc_ff <= {acc_ff[PROD_W-2:0], trial_ge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end
            end
         end
      end
   end

   // saturate quotient to the signed position range
   assign quot = ((acc_ff >> (PW - 1)) != '0) ? POS_MAX : acc_ff[PW-1:0];
   assign rem  = rem_ff;
   assign done = done_ff;

endmodule

// File: rtl/core/tppc_datapath.sv
// tppc_datapath: position, tempo and beat state, period registers, result
// register and the shared multiply-divide unit
// depends on tppc_pkg and tppc_muldiv

module tppc_datapath
   import tppc_pkg::*;
#(
   parameter int PW         = POS_W_DEF,
   parameter int FADE_STEPS = FADE_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  logic [CMD_W-1:0]        req_command,
   input  logic [PLAY_COUNT_W-1:0] req_play_count,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [PERIOD_W-1:0]     csr_wdata,
   input  ctrl_cmd_type            cmd,
   output dp_status_type           status,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [INDEX_W-1:0]      rsp_source_index,
   output logic [OUTPOS_W-1:0]     rsp_out_position
);

   localparam int FS_W = $clog2(FADE_STEPS + 1);
   localparam logic [PW-1:0] POS_MAX = {1'b0, {(PW-1){1'b1}}};
   localparam logic [PW-1:0] POS_MIN = {1'b1, {(PW-1){1'b0}}};

   function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] x, input logic [PW-1:0] y);
      logic [PW:0] s;
      s = {x[PW-1], x} + {y[PW-1], y};
      if (s[PW] != s[PW-1]) begin
         sat_add = s[PW] ? POS_MIN : POS_MAX;
      end else begin
         sat_add = s[PW-1:0];
      end
   endfunction

   function automatic logic [PW-1:0] sat_sub(input logic [PW-1:0] x, input logic [PW-1:0] y);
      logic [PW:0] s;
      s = {x[PW-1], x} - {y[PW-1], y};
      if (s[PW] != s[PW-1]) begin
         sat_sub = s[PW] ? POS_MIN : POS_MAX;
      end else begin
         sat_sub = s[PW-1:0];
      end
   endfunction

   function automatic logic [PW-1:0] clamp0(input logic [PW-1:0] x);
      clamp0 = x[PW-1] ? '0 : x;
   endfunction

   function automatic logic [PW-1:0] mag(input logic [PW-1:0] x);
      mag = x[PW-1] ? (~x + PW'(1)) : x;
   endfunction

   // state registers
   logic [PERIOD_W-1:0]     normal_ff, target_ff, cp_ff, newp_ff;
   logic [PERIOD_W-1:0]     newp_in, cp_in;
   logic [PW-1:0]           pp_ff, sp_ff, bm_ff;
   logic [PW-1:0]           pp_in, sp_in, bm_in;
   logic [FS_W-1:0]         fs_ff, fs_in;
   logic [CMD_W-1:0]        code_ff;
   logic [PLAY_COUNT_W-1:0] pc_ff;
   logic [DIV_W-1:0]        rem1_ff;
   logic                    rem_neg_ff;
   logic [PERIOD_W-1:0]     phase_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]      idx_ff;
   logic [OUTPOS_W-1:0]     opos_ff;

   // multiply-divide operands and results
   logic [PW-1:0]    md_a;
   logic [MUL_W-1:0] md_b;
   logic [DIV_W-1:0] md_d;
   logic             md_done;
   logic [PW-1:0]    md_quot;
   logic [DIV_W-1:0] md_rem;

   // derived values
   logic [PW-1:0]       pc_pos;
   logic [PW-1:0]       cp_ext;
   logic [PW-1:0]       sync_x;
   logic [PERIOD_W:0]   fade_diff;
   logic [PERIOD_W-1:0] fade_mag;
   logic [PW-1:0]       sync_delta;
   logic [PW-1:0]       mark_mod;
   logic [PW-1:0]       phase_diff;
   logic [DIV_W-1:0]    trunc_amount;
   logic [WIDE_W-1:0]   quot_wide;
   logic [WIDE_W-1:0]   pp_wide;

   // play count as a position
   if (PW > PLAY_COUNT_W) begin : g_pc_ext
      assign pc_pos = {{(PW-PLAY_COUNT_W){1'b0}}, pc_ff};
   end else begin : g_pc_sat
      assign pc_pos = (pc_ff > PLAY_COUNT_W'(POS_MAX)) ? POS_MAX : PW'(pc_ff);
   end

   assign cp_ext       = PW'(cp_ff);
   assign sync_x       = sat_sub(pc_pos, bm_ff);
   assign fade_diff    = {1'b0, normal_ff} - {1'b0, target_ff};
   assign fade_mag     = fade_diff[PERIOD_W] ? PERIOD_W'(~fade_diff + 1'b1)
                                             : fade_diff[PERIOD_W-1:0];
   assign trunc_amount = rem1_ff - md_rem;
   assign sync_delta   = rem_neg_ff ? (~PW'(trunc_amount) + PW'(1)) : PW'(trunc_amount);
   assign mark_mod     = bm_ff[PW-1] ? (~PW'(md_rem[PERIOD_W-1:0]) + PW'(1))
                                     : PW'(md_rem[PERIOD_W-1:0]);
   assign phase_diff   = PW'(phase_ff) - mark_mod;
   assign quot_wide    = WIDE_W'(md_quot);
   assign pp_wide      = WIDE_W'(pp_ff);

   // operand selection
   always_comb begin
      md_a = pp_ff;
      md_b = normal_ff;
      md_d = DIV_W'(cp_ff);
      case (cmd.md_src)
         MD_TICK: begin
            md_a = pp_ff;
            md_b = normal_ff;
            md_d = DIV_W'(cp_ff);
         end
         MD_TEMPO: begin
            md_a = sp_ff;
            md_b = newp_ff;
            md_d = DIV_W'(normal_ff);
         end
         MD_FASTER: begin
            md_a = cp_ext;
            md_b = Q16_ONE;
            md_d = DIV_W'(SEMI_Q16);
         end
         MD_SLOWER: begin
            md_a = cp_ext;
            md_b = SEMI_Q16;
            md_d = DIV_W'(Q16_ONE);
         end
         MD_SLOWER3: begin
            md_a = cp_ext;
            md_b = SEMI3_Q16;
            md_d = DIV_W'(Q16_ONE);
         end
         MD_FADE: begin
            md_a = PW'(fade_mag);
            md_b = MUL_W'(fs_ff);
            md_d = DIV_W'(FADE_STEPS);
         end
         MD_SYNC_REM: begin
            md_a = mag(sync_x);
            md_b = MUL_W'(1);
            md_d = {cp_ff, 3'b000};
         end
         MD_SYNC_Q4: begin
            md_a = PW'(rem1_ff);
            md_b = MUL_W'(1);
            md_d = DIV_W'(cp_ff >> 2);
         end
         MD_PHASE_POS: begin
            md_a = pp_ff;
            md_b = MUL_W'(1);
            md_d = DIV_W'(cp_ff);
         end
         MD_PHASE_MARK: begin
            md_a = mag(bm_ff);
            md_b = MUL_W'(1);
            md_d = DIV_W'(cp_ff);
         end
         default: begin
            md_a = pp_ff;
         end
      endcase
   end

   tppc_muldiv #(
      .PW (PW)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (cmd.md_start),
      .a     (md_a),
      .b     (md_b),
      .d     (md_d),
      .done  (md_done),
      .quot  (md_quot),
      .rem   (md_rem)
   );

   // next state
   always_comb begin
      pp_in        = pp_ff;
      sp_in        = sp_ff;
      bm_in        = bm_ff;
      cp_in        = cp_ff;
      fs_in        = fs_ff;
      newp_in      = newp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (cmd.upd)
         UPD_TICK: begin
            sp_in        = md_quot;
            pp_in        = sat_add(pp_ff, PW'(1));
            rsp_valid_in = 1'b1;
         end
         UPD_SIMPLE: begin
            case (code_ff)
               CMD_BACK_FINE:   pp_in = clamp0(sat_sub(pp_ff, PW'(cp_ff[PERIOD_W-1:7])));
               CMD_FWD_FINE:    pp_in = clamp0(sat_add(pp_ff, PW'(cp_ff[PERIOD_W-1:7])));
               CMD_FWD_EIGHTH:  pp_in = clamp0(sat_add(pp_ff, PW'(cp_ff[PERIOD_W-1:3])));
               CMD_BACK_1:      pp_in = clamp0(sat_sub(pp_ff, cp_ext));
               CMD_FWD_1:       pp_in = clamp0(sat_add(pp_ff, cp_ext));
               CMD_BACK_4:      pp_in = clamp0(sat_sub(pp_ff, PW'({cp_ff, 2'b00})));
               CMD_FWD_4:       pp_in = clamp0(sat_add(pp_ff, PW'({cp_ff, 2'b00})));
               CMD_BACK_8:      pp_in = clamp0(sat_sub(pp_ff, PW'({cp_ff, 3'b000})));
               CMD_FWD_8:       pp_in = clamp0(sat_add(pp_ff, PW'({cp_ff, 3'b000})));
               CMD_MARK_MASTER: bm_in = pc_pos;
               CMD_MARK_TARGET: bm_in = sat_sub(pp_ff, PW'({cp_ff, 3'b000}));
               CMD_REWIND:      pp_in = '0;
               CMD_RESET_PLAY: begin
                  pp_in = '0;
                  sp_in = '0;
                  cp_in = normal_ff;
               end
               default: pp_in = pp_ff;
            endcase
         end
         UPD_FADE_STEP: begin
            if (code_ff == CMD_FADE_NORMAL) begin
               if (fs_ff < FS_W'(FADE_STEPS)) fs_in = fs_ff + 1'b1;
            end else begin
               if (fs_ff != '0) fs_in = fs_ff - 1'b1;
            end
         end
         UPD_NEWP: begin
            case (code_ff)
               CMD_FADE_NORMAL, CMD_FADE_TARGET: begin
                  newp_in = fade_diff[PERIOD_W] ? target_ff - md_quot[PERIOD_W-1:0]
                                                : target_ff + md_quot[PERIOD_W-1:0];
               end
               CMD_TEMPO_NORMAL: newp_in = normal_ff;
               CMD_TEMPO_TARGET: newp_in = target_ff;
               default: begin
                  if (md_quot == '0) begin
                     newp_in = PERIOD_W'(1);
                  end else if (quot_wide > WIDE_W'(PERIOD_MAX)) begin
                     newp_in = PERIOD_MAX;
                  end else begin
                     newp_in = md_quot[PERIOD_W-1:0];
                  end
               end
            endcase
         end
         UPD_TEMPO: begin
            cp_in = newp_ff;
            pp_in = clamp0(md_quot);
         end
         UPD_SYNC_REM: begin
            bm_in = sync_x[PW-1] ? (~PW'(md_rem) + PW'(1)) : PW'(md_rem);
         end
         UPD_SYNC_POS: begin
            pp_in = clamp0(sat_add(pp_ff, sync_delta));
         end
         UPD_PHASE_MARK: begin
            pp_in = clamp0(sat_add(bm_ff, phase_diff));
         end
         default: pp_in = pp_ff;
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         normal_ff    <= PERIOD_RESET;
         target_ff    <= PERIOD_RESET;
         cp_ff        <= PERIOD_RESET;
         pp_ff        <= '0;
         sp_ff        <= '0;
         bm_ff        <= '0;
         fs_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pp_ff        <= pp_in;
         sp_ff        <= sp_in;
         bm_ff        <= bm_in;
         cp_ff        <= cp_in;
         fs_ff        <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == CSR_NORMAL) begin
               normal_ff <= (csr_wdata == '0) ? PERIOD_W'(1) : csr_wdata;
            end else begin
               target_ff <= (csr_wdata == '0) ? PERIOD_W'(1) : csr_wdata;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      newp_ff <= newp_in;
      if (load) begin
         code_ff <= req_command;
         pc_ff   <= req_play_count;
      end
      if (cmd.upd == UPD_SYNC_REM) begin
         rem1_ff    <= md_rem;
         rem_neg_ff <= sync_x[PW-1];
      end
      if (cmd.upd == UPD_PHASE_POS) begin
         phase_ff <= md_rem[PERIOD_W-1:0];
      end
      if (cmd.upd == UPD_TICK) begin
         idx_ff  <= (quot_wide > WIDE_W'(INDEX_MAX)) ? INDEX_MAX : md_quot[INDEX_W-1:0];
         opos_ff <= (pp_wide > WIDE_W'(OUTPOS_MAX)) ? OUTPOS_MAX : pp_wide[OUTPOS_W-1:0];
      end
   end

   assign status.md_done  = md_done;
   assign status.rsp_free = ~rsp_valid_ff | rsp_ready;
   assign status.q4_zero  = (cp_ff[PERIOD_W-1:2] == '0);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_source_index = idx_ff;
   assign rsp_out_position = opos_ff;

endmodule

// File: rtl/core/tppc_ctrl.sv
// tppc_ctrl: sequencer that takes items and steps the datapath through
// multiply-divide passes and state updates; depends on tppc_pkg

module tppc_ctrl
   import tppc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_action,
   input  logic [CMD_W-1:0] req_command,
   input  dp_status_type    status,
   output logic             req_ready,
   output ctrl_cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WAIT,
      S_TICK_OUT,
      S_SYNC_REM,
      S_SYNC_Q4_GO,
      S_SYNC_POS,
      S_PHASE_POS,
      S_PHASE_MARK_GO,
      S_PHASE_MARK,
      S_FADE_GO,
      S_NEWP,
      S_TEMPO_GO,
      S_TEMPO
   } state_type;

   state_type        state_ff;
   state_type        after_ff;
   logic             ready_ff;
   logic             act_ff;
   logic [CMD_W-1:0] code_ff;
   ctrl_cmd_type     cmd_ff;

   // state, ready and datapath commands
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         after_ff        <= S_IDLE;
         ready_ff        <= 1'b1;
         cmd_ff.md_start <= 1'b0;
         cmd_ff.md_src   <= MD_TICK;
         cmd_ff.upd      <= UPD_NONE;
      end else begin
         cmd_ff.md_start <= 1'b0;
         cmd_ff.upd      <= UPD_NONE;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && ready_ff) begin
                  act_ff   <= req_action;
                  code_ff  <= req_command;
                  ready_ff <= 1'b0;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (act_ff == ACT_TICK) begin
                  cmd_ff.md_start <= 1'b1;
                  cmd_ff.md_src   <= MD_TICK;
                  after_ff        <= S_TICK_OUT;
                  state_ff        <= S_WAIT;
               end else begin
                  case (code_ff)
                     CMD_SYNC: begin
                        cmd_ff.md_start <= 1'b1;
                        cmd_ff.md_src   <= MD_SYNC_REM;
                        after_ff        <= S_SYNC_REM;
                        state_ff        <= S_WAIT;
                     end
                     CMD_RESTART_BEAT: begin
                        cmd_ff.md_start <= 1'b1;
                        cmd_ff.md_src   <= MD_PHASE_POS;
                        after_ff        <= S_PHASE_POS;
                        state_ff        <= S_WAIT;
                     end
                     CMD_FADE_NORMAL, CMD_FADE_TARGET: begin
                        cmd_ff.upd <= UPD_FADE_STEP;
                        state_ff   <= S_FADE_GO;
                     end
                     CMD_TEMPO_NORMAL, CMD_TEMPO_TARGET: begin
                        cmd_ff.upd <= UPD_NEWP;
                        state_ff   <= S_TEMPO_GO;
                     end
                     CMD_SEMI_UP: begin
                        cmd_ff.md_start <= 1'b1;
                        cmd_ff.md_src   <= MD_FASTER;
                        after_ff        <= S_NEWP;
                        state_ff        <= S_WAIT;
                     end
                     CMD_SEMI_DOWN: begin
                        cmd_ff.md_start <= 1'b1;
                        cmd_ff.md_src   <= MD_SLOWER;
                        after_ff        <= S_NEWP;
                        state_ff        <= S_WAIT;
                     end
                     CMD_SEMI3_DOWN: begin
                        cmd_ff.md_start <= 1'b1;
                        cmd_ff.md_src   <= MD_SLOWER3;
                        after_ff        <= S_NEWP;
                        state_ff        <= S_WAIT;
                     end
                     default: begin
                        cmd_ff.upd <= UPD_SIMPLE;
                        ready_ff   <= 1'b1;
                        state_ff   <= S_IDLE;
                     end
                  endcase
               end
            end
            S_WAIT: begin
               if (status.md_done) begin
                  state_ff <= after_ff;
               end
            end
            S_TICK_OUT: begin
               // hold the tick until the result register is free
               if (status.rsp_free) begin
                  cmd_ff.upd <= UPD_TICK;
                  ready_ff   <= 1'b1;
                  state_ff   <= S_IDLE;
               end
            end
            S_SYNC_REM: begin
               cmd_ff.upd <= UPD_SYNC_REM;
               if (status.q4_zero) begin
                  ready_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  state_ff <= S_SYNC_Q4_GO;
               end
            end
            S_SYNC_Q4_GO: begin
               cmd_ff.md_start <= 1'b1;
               cmd_ff.md_src   <= MD_SYNC_Q4;
               after_ff        <= S_SYNC_POS;
               state_ff        <= S_WAIT;
            end
            S_SYNC_POS: begin
               cmd_ff.upd <= UPD_SYNC_POS;
               ready_ff   <= 1'b1;
               state_ff   <= S_IDLE;
            end
            S_PHASE_POS: begin
               cmd_ff.upd <= UPD_PHASE_POS;
               state_ff   <= S_PHASE_MARK_GO;
            end
            S_PHASE_MARK_GO: begin
               cmd_ff.md_start <= 1'b1;
               cmd_ff.md_src   <= MD_PHASE_MARK;
               after_ff        <= S_PHASE_MARK;
               state_ff        <= S_WAIT;
            end
            S_PHASE_MARK: begin
               cmd_ff.upd <= UPD_PHASE_MARK;
               ready_ff   <= 1'b1;
               state_ff   <= S_IDLE;
            end
            S_FADE_GO: begin
               cmd_ff.md_start <= 1'b1;
               cmd_ff.md_src   <= MD_FADE;
               after_ff        <= S_NEWP;
               state_ff        <= S_WAIT;
            end
            S_NEWP: begin
               cmd_ff.upd <= UPD_NEWP;
               state_ff   <= S_TEMPO_GO;
            end
            S_TEMPO_GO: begin
               cmd_ff.md_start <= 1'b1;
               cmd_ff.md_src   <= MD_TEMPO;
               after_ff        <= S_TEMPO;
               state_ff        <= S_WAIT;
            end
            S_TEMPO: begin
               cmd_ff.upd <= UPD_TEMPO;
               ready_ff   <= 1'b1;
               state_ff   <= S_IDLE;
            end
            default: begin
               ready_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign cmd       = cmd_ff;

endmodule
